// ----- hdl/cpa_pkg.sv -----
// Shared types, codes and constants for the complex pointwise ALU.
`default_nettype none
package cpa_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUO_BITS      = 33;

    typedef enum logic [2:0] {
        CMD_MUL      = 3'd0,
        CMD_MUL_CONJ = 3'd1,
        CMD_DIV_ZERO = 3'd2,
        CMD_DIV_STAB = 3'd3,
        CMD_ADD      = 3'd4,
        CMD_SCALE    = 3'd5
    } t_cmd;

    localparam logic CFG_EPSILON = 1'b0;
    localparam logic CFG_SCALE   = 1'b1;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic               last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               guarded;
        logic               saturated;
        logic               last_out;
    } t_out_item;

    // Payload handed from cell to cell along the divider chain
    typedef struct packed {
        logic [2:0]          cmd;
        logic                last;
        logic                guard;
        logic                zero;
        logic                neg_re;
        logic                neg_im;
        logic                ovf_re;
        logic                ovf_im;
        logic [63:0]         mag_re;
        logic [63:0]         mag_im;
        logic [63:0]         den;
        logic [64:0]         rem_re;
        logic [64:0]         rem_im;
        logic [QUO_BITS-1:0] quo_re;
        logic [QUO_BITS-1:0] quo_im;
    } t_cell_data;

endpackage
`default_nettype wire

// ----- hdl/cpa_front.sv -----
// Front end: operand products, then signed sums, divisor and guard selection.
`default_nettype none
module cpa_front #(
    parameter int FRAC_BITS = cpa_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  cpa_pkg::t_in_item    i_item,
    input  wire  [30:0]          i_epsilon,
    input  wire  signed [31:0]   i_scale,
    output logic                 o_valid,
    input  wire                  i_ready,
    output cpa_pkg::t_cell_data  o_data
);
    import cpa_pkg::*;

    localparam int INT_BITS = 32 - FRAC_BITS;

    logic               r_a_valid;
    logic [2:0]         r_cmd;
    logic               r_last;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic [63:0]        r_sq_re, r_sq_im;
    logic signed [32:0] r_add_re, r_add_im;

    logic               r_b_valid;
    t_cell_data         r_b_data;
    t_cell_data         n_b_data;

    logic               a_ready;
    logic               b_ready;
    logic signed [31:0] mb_re, mb_im;
    logic signed [63:0] sq_re, sq_im;
    logic signed [64:0] sum_re, sum_im;
    logic [63:0]        den_sq, thr, den;
    logic               div_cmd, below;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    always_comb begin
        // Scale reuses the conjugate path with b = (scale, 0)
        if (i_item.command == CMD_SCALE) begin
            mb_re = i_scale;
            mb_im = '0;
        end else begin
            mb_re = i_item.b_re;
            mb_im = i_item.b_im;
        end
        sq_re = i_item.b_re * i_item.b_re;
        sq_im = i_item.b_im * i_item.b_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (a_ready && i_valid) begin
            r_cmd    <= i_item.command;
            r_last   <= i_item.last_in;
            r_p0     <= i_item.a_re * mb_re;
            r_p1     <= i_item.a_im * mb_im;
            r_p2     <= i_item.a_re * mb_im;
            r_p3     <= i_item.a_im * mb_re;
            r_sq_re  <= 64'(sq_re);
            r_sq_im  <= 64'(sq_im);
            r_add_re <= 33'(i_item.a_re) + 33'(i_item.b_re);
            r_add_im <= 33'(i_item.a_im) + 33'(i_item.b_im);
        end
    end

    always_comb begin
        case (r_cmd)
            CMD_MUL: begin
                sum_re = 65'(r_p0) - 65'(r_p1);
                sum_im = 65'(r_p2) + 65'(r_p3);
            end
            CMD_MUL_CONJ, CMD_DIV_ZERO, CMD_DIV_STAB, CMD_SCALE: begin
                sum_re = 65'(r_p0) + 65'(r_p1);
                sum_im = 65'(r_p3) - 65'(r_p2);
            end
            CMD_ADD: begin
                sum_re = 65'(r_add_re);
                sum_im = 65'(r_add_im);
            end
            default: begin
                sum_re = '0;
                sum_im = '0;
            end
        endcase

        den_sq  = r_sq_re + r_sq_im;
        thr     = 64'(i_epsilon) << FRAC_BITS;
        div_cmd = (r_cmd == CMD_DIV_ZERO) || (r_cmd == CMD_DIV_STAB);
        below   = den_sq < thr;
        if (below) begin
            den = (r_cmd == CMD_DIV_ZERO) ? 64'd0 : thr;
        end else begin
            den = den_sq;
        end

        n_b_data        = '0;
        n_b_data.cmd    = r_cmd;
        n_b_data.last   = r_last;
        n_b_data.neg_re = sum_re[64];
        n_b_data.neg_im = sum_im[64];
        n_b_data.mag_re = sum_re[64] ? 64'(-sum_re) : 64'(sum_re);
        n_b_data.mag_im = sum_im[64] ? 64'(-sum_im) : 64'(sum_im);
        n_b_data.den    = den;
        n_b_data.zero   = (den == 64'd0);
        n_b_data.guard  = div_cmd && (below || (den == 64'd0));
        // Quotient would not fit the integer bits: answer saturates
        n_b_data.ovf_re = (n_b_data.mag_re >> INT_BITS) >= den;
        n_b_data.ovf_im = (n_b_data.mag_im >> INT_BITS) >= den;
        n_b_data.rem_re = 65'(n_b_data.mag_re >> INT_BITS);
        n_b_data.rem_im = 65'(n_b_data.mag_im >> INT_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule
`default_nettype wire

// ----- hdl/cpa_div_cell.sv -----
// One restoring-division cell: decides one quotient bit for both parts.
`default_nettype none
module cpa_div_cell #(
    parameter int FRAC_BITS = cpa_pkg::FRAC_BITS_DEF,
    parameter int BIT       = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  cpa_pkg::t_cell_data  i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output cpa_pkg::t_cell_data  o_data
);
    import cpa_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic       nb_re, nb_im;
    logic [64:0] sh_re, sh_im;
    logic       ge_re, ge_im;

    // Next numerator bit of mag << (FRAC_BITS + 1)
    generate
        if (BIT >= FRAC_BITS + 1) begin : g_mag_bit
            assign nb_re = i_data.mag_re[BIT-FRAC_BITS-1];
            assign nb_im = i_data.mag_im[BIT-FRAC_BITS-1];
        end else begin : g_zero_bit
            assign nb_re = 1'b0;
            assign nb_im = 1'b0;
        end
    endgenerate

    always_comb begin
        sh_re  = {i_data.rem_re[63:0], nb_re};
        sh_im  = {i_data.rem_im[63:0], nb_im};
        ge_re  = sh_re >= {1'b0, i_data.den};
        ge_im  = sh_im >= {1'b0, i_data.den};
        n_data = i_data;
        n_data.rem_re = ge_re ? sh_re - {1'b0, i_data.den} : sh_re;
        n_data.rem_im = ge_im ? sh_im - {1'b0, i_data.den} : sh_im;
        n_data.quo_re = {i_data.quo_re[QUO_BITS-2:0], ge_re};
        n_data.quo_im = {i_data.quo_im[QUO_BITS-2:0], ge_im};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ----- hdl/cpa_back.sv -----
// Back end: rounding, result select and saturation into the output register.
`default_nettype none
module cpa_back #(
    parameter int FRAC_BITS = cpa_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  cpa_pkg::t_cell_data  i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output cpa_pkg::t_out_item   o_item
);
    import cpa_pkg::*;

    logic        r_valid;
    t_out_item   r_item;
    t_out_item   n_item;
    logic [63:0] fin_re, fin_im;
    logic        neg_re, neg_im;
    logic        clip_re, clip_im;
    logic [31:0] sat_re, sat_im;

    function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
        // bit 32 flags a clip
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF) begin
                sat32 = {1'b1, 32'h7FFF_FFFF};
            end else begin
                sat32 = {1'b0, mag[31:0]};
            end
        end else begin
            if (mag > 64'h8000_0000) begin
                sat32 = {1'b1, 32'h8000_0000};
            end else begin
                sat32 = {1'b0, 32'(-mag[31:0])};
            end
        end
    endfunction

    always_comb begin
        neg_re = i_data.neg_re;
        neg_im = i_data.neg_im;
        case (i_data.cmd)
            CMD_MUL, CMD_MUL_CONJ, CMD_SCALE: begin
                fin_re = (i_data.mag_re >> FRAC_BITS) + 64'(i_data.mag_re[FRAC_BITS-1]);
                fin_im = (i_data.mag_im >> FRAC_BITS) + 64'(i_data.mag_im[FRAC_BITS-1]);
            end
            CMD_DIV_ZERO, CMD_DIV_STAB: begin
                if (i_data.zero) begin
                    fin_re = '0;
                    fin_im = '0;
                end else begin
                    fin_re = i_data.ovf_re ? (64'd1 << QUO_BITS)
                                           : (64'(i_data.quo_re) + 64'd1) >> 1;
                    fin_im = i_data.ovf_im ? (64'd1 << QUO_BITS)
                                           : (64'(i_data.quo_im) + 64'd1) >> 1;
                end
            end
            CMD_ADD: begin
                fin_re = i_data.mag_re;
                fin_im = i_data.mag_im;
            end
            default: begin
                fin_re = '0;
                fin_im = '0;
                neg_re = 1'b0;
                neg_im = 1'b0;
            end
        endcase
        {clip_re, sat_re} = sat32(neg_re, fin_re);
        {clip_im, sat_im} = sat32(neg_im, fin_im);
        n_item.res_re    = sat_re;
        n_item.res_im    = sat_im;
        n_item.guarded   = i_data.guard;
        n_item.saturated = clip_re || clip_im;
        n_item.last_out  = i_data.last;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ----- hdl/complex_pointwise_alu_unit.sv -----
// Top level of the complex pointwise ALU: config registers and the cell chain.
// Takes one transaction per cycle while the output is not stalled: two front
// stages form the products and divisor, a chain of 33 division cells (one
// quotient bit each, shared by the real and imaginary parts) follows, and a
// final stage rounds and saturates. Every command travels the same chain, so
// results leave in order. Each stage holds its own valid bit and accepts when
// empty or draining, so an output stall fills bubbles before it stops the
// input. Write epsilon and scale_factor only while no transaction is in flight.
`default_nettype none
module complex_pointwise_alu_unit #(
    parameter int FRAC_BITS = cpa_pkg::FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  cpa_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output cpa_pkg::t_out_item  o_item,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire  [31:0]         i_cfg_data
);
    import cpa_pkg::*;

    logic [30:0]        r_epsilon;
    logic signed [31:0] r_scale;

    logic       link_valid [QUO_BITS+1];
    logic       link_ready [QUO_BITS+1];
    t_cell_data link_data  [QUO_BITS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= 31'd1;
            r_scale   <= 32'sd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EPSILON: r_epsilon <= i_cfg_data[30:0];
                CFG_SCALE:   r_scale   <= i_cfg_data;
                default:     r_epsilon <= r_epsilon;
            endcase
        end
    end

    cpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .i_epsilon (r_epsilon),
        .i_scale   (r_scale),
        .o_valid   (link_valid[0]),
        .i_ready   (link_ready[0]),
        .o_data    (link_data[0])
    );

    // Cell k decides quotient bit QUO_BITS-1-k
    generate
        for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
            cpa_div_cell #(
                .FRAC_BITS (FRAC_BITS),
                .BIT       (QUO_BITS - 1 - k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (link_valid[k]),
                .o_ready (link_ready[k]),
                .i_data  (link_data[k]),
                .o_valid (link_valid[k+1]),
                .i_ready (link_ready[k+1]),
                .o_data  (link_data[k+1])
            );
        end
    endgenerate

    cpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (link_valid[QUO_BITS]),
        .o_ready (link_ready[QUO_BITS]),
        .i_data  (link_data[QUO_BITS]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire
